// ===== rtl/core/ssnk_pkg.sv =====
package ssnk_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic               ok;
    logic [9:0]         nearest_index;
    logic signed [31:0] nearest_value;
    logic [10:0]        entry_count;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_interval;
    logic rd_first;
    logic rd_last;
    logic rd_cur;
    logic rd_nxt;
    logic rd_val;
    logic wr;
    logic set_est;
    logic step;
    logic pick_nxt;
    logic clr;
    logic fin_interval;
    logic emit;
  } ssnk_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       key_gt_last;
    logic       multi;
    logic       interval_zero;
    logic       div_done;
    logic       up;
    logic       at_edge;
    logic       bracket;
    logic       nxt_nearer;
  } ssnk_sts_t;

endpackage

// ===== rtl/core/ssnk_ram.sv =====
module ssnk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ssnk_div.sv =====
module ssnk_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [32:0] divisor,
  output logic [32:0] quotient,
  output logic        done
);

  logic [32:0] rem_r, rem_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [32:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r;
  logic [33:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[32]} - {1'b0, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[32]};
      end
      quo_nxt  = {quo_r[31:0], ~trial[33]};
      cnt_nxt  = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= busy_r && (cnt_r == 6'd1) && !start;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== rtl/core/ssnk_dp.sv =====
module ssnk_dp
  import ssnk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_req,
  input  ssnk_cmd_t cmd,
  output ssnk_sts_t sts,
  output out_res_t  res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]         kind_r;
  logic signed [31:0] key_r, val_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [31:0]        interval_r;
  logic signed [31:0] first_r, last_r, ck_r;
  logic [AW-1:0]      cur_r;
  logic               up_r;
  logic               ok_r;
  logic [AW-1:0]      raddr;
  logic [31:0]        kdata, vdata;
  logic               div_start;
  logic [32:0]        dividend, divisor, quotient;
  logic               div_done;
  logic [AW-1:0]      nxt_idx;
  logic signed [32:0] dck, dnk;
  logic [CW-1:0]      last_idx;
  logic signed [32:0] diff;

  assign last_idx = count_r - CW'(1);
  assign nxt_idx  = up_r ? cur_r + AW'(1) : cur_r - AW'(1);

  always_comb begin
    raddr = cur_r;
    if (cmd.rd_first) begin
      raddr = '0;
    end else if (cmd.rd_last) begin
      raddr = last_idx[AW-1:0];
    end else if (cmd.rd_nxt) begin
      raddr = nxt_idx;
    end
  end

  ssnk_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_keys (
    .clk(clk), .we(cmd.wr), .waddr(count_r[AW-1:0]), .wdata(key_r),
    .raddr(raddr), .rdata(kdata)
  );

  ssnk_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vals (
    .clk(clk), .we(cmd.wr), .waddr(count_r[AW-1:0]), .wdata(val_r),
    .raddr(raddr), .rdata(vdata)
  );

  assign diff = 33'(key_r) - 33'(first_r);

  always_comb begin
    if (cmd.div_interval) begin
      dividend = {1'b0, 32'(33'(last_r) - 33'(first_r))};
      divisor  = 33'(count_r - CW'(1));
    end else begin
      dividend = diff[32] ? -diff : diff;
      divisor  = {1'b0, interval_r};
    end
  end

  assign div_start = cmd.div_start;

  ssnk_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(divisor), .quotient(quotient), .done(div_done)
  );

  assign dck = key_r - 33'(ck_r);
  assign dnk = 33'($signed(kdata)) - key_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.wr) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      interval_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr || (cmd.wr && count_r == '0)) begin
        interval_r <= '0;
      end else if (cmd.fin_interval) begin
        interval_r <= quotient[31:0];
      end
    end
    if (cmd.load) begin
      kind_r <= in_req.kind;
      key_r  <= in_req.key;
      val_r  <= in_req.sample_value;
      ok_r   <= 1'b0;
    end
    if (cmd.wr) begin
      ok_r <= 1'b1;
      if (count_r == '0) begin
        first_r <= key_r;
      end
      last_r <= key_r;
    end
    if (cmd.clr) begin
      ok_r <= 1'b1;
    end
    if (cmd.rd_cur || cmd.step) begin
      ck_r <= kdata;
    end
    if (cmd.set_est) begin
      if (interval_r == '0 || diff[32]) begin
        cur_r <= '0;
      end else if (quotient > 33'(last_idx)) begin
        cur_r <= last_idx[AW-1:0];
      end else begin
        cur_r <= quotient[AW-1:0];
      end
    end
    if (cmd.rd_cur && cmd.set_est == 1'b0 && cmd.step == 1'b0) begin
      up_r <= !($signed(kdata) > key_r);
    end
    if (cmd.step || cmd.pick_nxt) begin
      cur_r <= nxt_idx;
    end
    if (cmd.rd_val) begin
      ok_r <= 1'b1;
    end
  end

  assign sts.kind          = kind_r;
  assign sts.empty         = (count_r == '0);
  assign sts.full          = (count_r == CW'(DEPTH));
  assign sts.key_gt_last   = key_r > last_r;
  assign sts.multi         = (count_r > CW'(1));
  assign sts.interval_zero = (interval_r == '0);
  assign sts.div_done      = div_done;
  assign sts.up            = up_r;
  assign sts.at_edge       = up_r ? (33'(cur_r) >= 33'(last_idx)) : (cur_r == '0);
  assign sts.bracket       = up_r ? (ck_r <= key_r && $signed(kdata) >= key_r)
                                  : ($signed(kdata) <= key_r && ck_r >= key_r);
  assign sts.nxt_nearer    = up_r ? (dck > dnk) : (-dck > -dnk);

  always_comb begin
    res.ok            = ok_r;
    res.nearest_index = '0;
    res.nearest_value = '0;
    res.entry_count   = 11'(count_r);
    if (kind_r == KIND_QUERY && ok_r) begin
      res.nearest_index = 10'(cur_r);
      res.nearest_value = vdata;
    end
  end

endmodule

// ===== rtl/core/ssnk_ctrl.sv =====
module ssnk_ctrl
  import ssnk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ssnk_sts_t sts,
  output ssnk_cmd_t cmd,
  output logic      out_valid
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_IDIV  = 4'd2;
  localparam logic [3:0] S_QDIV  = 4'd3;
  localparam logic [3:0] S_QRDC  = 4'd4;
  localparam logic [3:0] S_QDIR  = 4'd5;
  localparam logic [3:0] S_WRDN  = 4'd6;
  localparam logic [3:0] S_WRDC  = 4'd7;
  localparam logic [3:0] S_WCMP  = 4'd8;
  localparam logic [3:0] S_VAL   = 4'd9;
  localparam logic [3:0] S_VALW  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_IRD   = 4'd12;

  logic [3:0] st_r, st_nxt;

  always_comb begin
    st_nxt    = st_r;
    cmd       = '0;
    out_valid = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          st_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.kind == KIND_CLEAR) begin
          cmd.clr = 1'b1;
          st_nxt  = S_DONE;
        end else if (sts.kind == KIND_APPEND) begin
          if (!sts.full && (sts.empty || sts.key_gt_last)) begin
            cmd.wr = 1'b1;
            st_nxt = S_IRD;
          end else begin
            st_nxt = S_DONE;
          end
        end else if (sts.kind == KIND_QUERY && !sts.empty) begin
          cmd.div_start = 1'b1;
          st_nxt        = S_QDIV;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_IRD: begin
        if (sts.multi) begin
          cmd.div_start    = 1'b1;
          cmd.div_interval = 1'b1;
          st_nxt           = S_IDIV;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_IDIV: begin
        if (sts.div_done) begin
          cmd.fin_interval = 1'b1;
          st_nxt           = S_DONE;
        end
      end
      S_QDIV: begin
        if (sts.div_done) begin
          cmd.set_est = 1'b1;
          st_nxt      = S_QRDC;
        end
      end
      S_QRDC: begin
        if (sts.interval_zero) begin
          st_nxt = S_VAL;
        end else begin
          st_nxt = S_QDIR;
        end
      end
      S_QDIR: begin
        cmd.rd_cur = 1'b1;
        st_nxt     = S_WRDN;
      end
      S_WRDN: begin
        if (sts.at_edge) begin
          st_nxt = S_VAL;
        end else begin
          cmd.rd_nxt = 1'b1;
          st_nxt     = S_WCMP;
        end
      end
      S_WCMP: begin
        if (!sts.bracket) begin
          cmd.step = 1'b1;
          st_nxt   = S_WRDC;
        end else begin
          if (sts.nxt_nearer) begin
            cmd.pick_nxt = 1'b1;
          end
          st_nxt = S_VAL;
        end
      end
      S_WRDC: begin
        st_nxt = S_WRDN;
      end
      S_VAL: begin
        st_nxt = S_VALW;
      end
      S_VALW: begin
        cmd.rd_val = 1'b1;
        st_nxt     = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        cmd.emit  = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);

endmodule

// ===== rtl/core/sorted_sample_nearest_key_lookup.sv =====
// Each request is taken while busy is low and gives one result, shown for a single cycle
// with out_valid; the receiver cannot stall, so it must take every result as it appears.
// A clear, a rejected append, a query of an empty buffer and an unused kind go from decode
// straight to the result state; the first append after a clear passes a check state on the way.
// Any later stored append runs the 33-step bit-serial divider that recomputes the mean key interval.
// A query runs the divider to estimate a start index and then walks, reading one key per
// step from the key RAM.
module sorted_sample_nearest_key_lookup
  import ssnk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  ssnk_cmd_t cmd;
  ssnk_sts_t sts;

  ssnk_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd), .out_valid(out_valid)
  );

  ssnk_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts), .res(out_res)
  );

endmodule

// ===== tb/sv/sorted_sample_nearest_key_lookup_tb.sv =====
module sorted_sample_nearest_key_lookup_tb;
  import ssnk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;

  sorted_sample_nearest_key_lookup dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic signed [31:0] mdl_keys[DEPTH];
  logic signed [31:0] mdl_vals[DEPTH];
  int unsigned        mdl_count;
  logic [31:0]        mdl_interval;

  in_req_t  pending_reqs[$];
  out_res_t expected_res[$];
  int       fail_count;
  int       gap_left;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic longint absdiff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic out_res_t predict_lookup(in_req_t req);
    out_res_t   res;
    longint     n, cur, nxt, est, tgt, ck, nk;
    bit         up, brk;
    logic [31:0] span;
    res = '0;
    tgt = req.key;
    case (req.kind)
      KIND_CLEAR: begin
        mdl_count = 0;
        mdl_interval = '0;
        res.ok = 1'b1;
      end
      KIND_APPEND: begin
        if (mdl_count < DEPTH && (mdl_count == 0 || mdl_keys[mdl_count-1] < req.key)) begin
          mdl_keys[mdl_count] = req.key;
          mdl_vals[mdl_count] = req.sample_value;
          mdl_count++;
          if (mdl_count > 1) begin
            span = 32'(longint'(mdl_keys[mdl_count-1]) - longint'(mdl_keys[0]));
            mdl_interval = span / 32'(mdl_count - 1);
          end else begin
            mdl_interval = '0;
          end
          res.ok = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (mdl_count > 0) begin
          n = mdl_count;
          cur = 0;
          if (mdl_interval != 0) begin
            est = (tgt - longint'(mdl_keys[0])) / longint'({32'd0, mdl_interval});
            if (est > n - 1) est = n - 1;
            if (est < 0) est = 0;
            cur = est;
            up = !(mdl_keys[cur] > tgt);
            forever begin
              nxt = up ? cur + 1 : cur - 1;
              if (nxt < 0 || nxt >= n) break;
              ck = mdl_keys[cur];
              nk = mdl_keys[nxt];
              brk = up ? (ck <= tgt && nk >= tgt) : (nk <= tgt && ck >= tgt);
              if (!brk) begin
                cur = nxt;
                continue;
              end
              if (absdiff(tgt, ck) > absdiff(tgt, nk)) cur = nxt;
              break;
            end
          end
          res.ok = 1'b1;
          res.nearest_index = 10'(cur);
          res.nearest_value = mdl_vals[cur];
        end
      end
      default: ;
    endcase
    res.entry_count = 11'(mdl_count);
    return res;
  endfunction

  function automatic in_req_t mk(logic [1:0] k, logic [31:0] key, logic [31:0] v);
    in_req_t r;
    r.kind = k;
    r.key = key;
    r.sample_value = v;
    return r;
  endfunction

  task automatic queue_req(in_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      expected_res.insert(expected_res.size(), predict_lookup(in_req));
      void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && gap_len() == 0) begin
        in_req <= pending_reqs[0];
      end else begin
        start <= 1'b0;
        gap_left <= gap_len();
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        in_req <= pending_reqs[0];
      end
    end
  end

  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result %p", out_res);
        fail_count++;
      end else begin
        e = expected_res.pop_front();
        if (out_res.ok !== e.ok) begin
          $error("ok: expected %0d, got %0d", e.ok, out_res.ok);
          fail_count++;
        end
        if (out_res.nearest_index !== e.nearest_index) begin
          $error("nearest_index: expected %0d, got %0d", e.nearest_index,
                 out_res.nearest_index);
          fail_count++;
        end
        if (out_res.nearest_value !== e.nearest_value) begin
          $error("nearest_value: expected %0d, got %0d", e.nearest_value,
                 out_res.nearest_value);
          fail_count++;
        end
        if (out_res.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, out_res.entry_count);
          fail_count++;
        end
      end
    end
  end

  task automatic add_rand_query(logic signed [31:0] lo, logic signed [31:0] hi);
    int r;
    logic [31:0] k;
    r = $urandom_range(0, 9);
    if (r == 0) k = $urandom();
    else k = 32'(longint'(lo) + longint'($urandom_range(0, 1000)) *
                 (longint'(hi) - longint'(lo) + 2) / 1000 - 1);
    queue_req(mk(KIND_QUERY, k, $urandom()));
  endtask

  initial begin
    logic signed [31:0] k, first, step;
    int n;
    fail_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_req(mk(KIND_QUERY, 32'd5, 32'd0));
    queue_req(mk(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_req(mk(KIND_APPEND, 32'sh8000_0000, 32'hFFFF_FFFF));
    queue_req(mk(KIND_QUERY, 32'sh7FFF_FFFF, 32'd0));
    queue_req(mk(KIND_APPEND, 32'sh8000_0000, 32'd1));
    queue_req(mk(KIND_APPEND, 32'sh7FFF_FFFF, 32'h8000_0000));
    queue_req(mk(KIND_QUERY, 32'sh7FFF_FFFF, 32'd0));
    queue_req(mk(KIND_QUERY, 32'sh8000_0000, 32'd0));
    queue_req(mk(KIND_QUERY, 32'sh0000_0000, 32'd0));
    queue_req(mk(KIND_QUERY, 32'shFFFF_FFFF, 32'd0));
    queue_req(mk(KIND_APPEND, 32'sh0000_0000, 32'd7));
    queue_req(mk(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_req(mk(KIND_APPEND, 32'd0, 32'd10));
    queue_req(mk(KIND_APPEND, 32'd1, 32'd11));
    queue_req(mk(KIND_APPEND, 32'd100, 32'd12));
    queue_req(mk(KIND_APPEND, 32'd101, 32'd13));
    queue_req(mk(KIND_QUERY, 32'd50, 32'd0));
    queue_req(mk(KIND_QUERY, 32'd51, 32'd0));
    queue_req(mk(KIND_QUERY, 32'd99, 32'd0));
    queue_req(mk(KIND_QUERY, -32'sd5, 32'd0));
    queue_req(mk(KIND_QUERY, 32'd500, 32'd0));

    // One pass fills the buffer to the brim so that a full buffer rejects appends.
    queue_req(mk(KIND_CLEAR, 32'd0, 32'd0));
    for (int i = 0; i < DEPTH; i++)
      queue_req(mk(KIND_APPEND, 32'(i * 3 - 1500), $urandom()));
    queue_req(mk(KIND_APPEND, 32'sh7FFF_FFFF, 32'd1));
    for (int i = 0; i < 8; i++) add_rand_query(-1500, 1600);

    while (pending_reqs.size() < 1400) begin
      queue_req(mk(KIND_CLEAR, $urandom(), $urandom()));
      n = $urandom_range(1, 40);
      first = $urandom();
      if ($urandom_range(0, 3) == 0) first = 32'sh8000_0000 + $urandom_range(0, 100);
      step = ($urandom_range(0, 1)) ? $urandom_range(1, 4) : $urandom_range(1, 20000000);
      k = first;
      for (int i = 0; i < n; i++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
          queue_req(mk(KIND_APPEND, k - $urandom_range(0, 3), $urandom()));
        end else if (r == 1) begin
          add_rand_query(first, k);
        end else begin
          queue_req(mk(KIND_APPEND, k, $urandom()));
          if (longint'(k) + 2 * longint'(step) > 64'sh7FFF_FFFF) break;
          k = k + $urandom_range(1, step * 2);
        end
      end
      repeat ($urandom_range(3, 15)) add_rand_query(first, k);
      if ($urandom_range(0, 9) == 0)
        queue_req(mk(KIND_UNUSED, $urandom(), $urandom()));
    end

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
